// ----- hw/rtl/gccb_pkg.sv -----
// ----------------------------------------------------------------------------
// gccb_pkg
// Types, constants and the level table shared by the glyph blend pipeline.
// ----------------------------------------------------------------------------
package gccb_pkg;

   localparam int CHAN_W   = 8;
   localparam int LEVEL_W  = 7;
   localparam int SUM_W    = 15;
   localparam int RECIP_W  = 13;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam int PIXEL_W  = 32;
   localparam int FORE_W   = 24;
   localparam int NUM_CHAN = 3;

   // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
   localparam logic [RECIP_W-1:0] DIV100_MUL   = 13'd5243;
   localparam int                 DIV100_SHIFT = 19;

   localparam logic [CHAN_W-1:0] COVER_EMPTY = 8'd0;
   localparam logic [CHAN_W-1:0] COVER_FULL  = 8'd255;

   typedef enum logic [0:0] {
      CSR_FORE_COLOR = 1'b0,
      CSR_BACK_COLOR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic sum_en;
      logic average;
   } chan_ctrl_type;

   // channel level in hundredths
   localparam logic [LEVEL_W-1:0] LEVEL_CENTS [256] = '{
      7'd0,7'd1,7'd1,7'd2,7'd2,7'd2,7'd3,7'd3,7'd4,7'd4,7'd4,7'd5,7'd5,7'd5,7'd6,7'd6,
      7'd7,7'd7,7'd7,7'd8,7'd8,7'd9,7'd9,7'd9,7'd10,7'd10,7'd11,7'd11,7'd11,7'd12,7'd12,7'd13,
      7'd13,7'd13,7'd14,7'd14,7'd14,7'd15,7'd15,7'd16,7'd16,7'd16,7'd17,7'd17,7'd18,7'd18,
      7'd18,7'd19,
      7'd19,7'd20,7'd20,7'd20,7'd21,7'd21,7'd21,7'd22,7'd22,7'd23,7'd23,7'd23,7'd24,7'd24,
      7'd25,7'd25,
      7'd25,7'd26,7'd26,7'd27,7'd27,7'd27,7'd28,7'd28,7'd29,7'd29,7'd29,7'd30,7'd30,7'd30,
      7'd31,7'd31,
      7'd32,7'd32,7'd32,7'd33,7'd33,7'd34,7'd34,7'd34,7'd35,7'd35,7'd36,7'd36,7'd36,7'd37,
      7'd37,7'd38,
      7'd38,7'd38,7'd39,7'd39,7'd39,7'd40,7'd40,7'd41,7'd41,7'd41,7'd42,7'd42,7'd43,7'd43,
      7'd43,7'd44,
      7'd44,7'd45,7'd45,7'd45,7'd46,7'd46,7'd46,7'd47,7'd47,7'd48,7'd48,7'd48,7'd49,7'd49,
      7'd50,7'd50,
      7'd50,7'd51,7'd51,7'd52,7'd52,7'd52,7'd53,7'd53,7'd54,7'd54,7'd54,7'd55,7'd55,7'd55,
      7'd56,7'd56,
      7'd57,7'd57,7'd57,7'd58,7'd58,7'd59,7'd59,7'd59,7'd60,7'd60,7'd61,7'd61,7'd61,7'd62,
      7'd62,7'd63,
      7'd63,7'd63,7'd64,7'd64,7'd64,7'd65,7'd65,7'd66,7'd66,7'd66,7'd67,7'd67,7'd68,7'd68,
      7'd68,7'd69,
      7'd69,7'd70,7'd70,7'd70,7'd71,7'd71,7'd71,7'd72,7'd72,7'd73,7'd73,7'd73,7'd74,7'd74,
      7'd75,7'd75,
      7'd75,7'd76,7'd76,7'd77,7'd77,7'd77,7'd78,7'd78,7'd79,7'd79,7'd79,7'd80,7'd80,7'd80,
      7'd81,7'd81,
      7'd82,7'd82,7'd82,7'd83,7'd83,7'd84,7'd84,7'd84,7'd85,7'd85,7'd86,7'd86,7'd86,7'd87,
      7'd87,7'd88,
      7'd88,7'd88,7'd89,7'd89,7'd89,7'd90,7'd90,7'd91,7'd91,7'd91,7'd92,7'd92,7'd93,7'd93,
      7'd93,7'd94,
      7'd94,7'd95,7'd95,7'd95,7'd96,7'd96,7'd96,7'd97,7'd97,7'd98,7'd98,7'd98,7'd99,7'd99,
      7'd100,7'd100
   };

   function automatic logic [LEVEL_W-1:0] level_of(input logic [CHAN_W-1:0] value);
      return LEVEL_CENTS[value];
   endfunction

endpackage

// ----- hw/rtl/gccb_channel.sv -----
// ----------------------------------------------------------------------------
// gccb_channel
// One color channel: weighted level sum, registered, then divide by 100
// and optional average with the destination channel.
// ----------------------------------------------------------------------------
module gccb_channel (
   input  logic                               clock,
   input  gccb_pkg::chan_ctrl_type            ctrl,
   input  logic [gccb_pkg::LEVEL_W-1:0]       fore_level,
   input  logic [gccb_pkg::LEVEL_W-1:0]       back_level,
   input  logic [gccb_pkg::CHAN_W-1:0]        coverage,
   input  logic [gccb_pkg::CHAN_W-1:0]        dest_chan,
   output logic [gccb_pkg::CHAN_W-1:0]        chan_out
);

   logic [gccb_pkg::CHAN_W-1:0] cov_inv;
   logic [gccb_pkg::SUM_W-1:0]  sum_in;
   logic [gccb_pkg::SUM_W-1:0]  sum_ff;
   logic [gccb_pkg::PROD_W-1:0] prod;
   logic [gccb_pkg::CHAN_W-1:0] mix;
   logic [gccb_pkg::CHAN_W:0]   pair_sum;

   // 255 - coverage
   assign cov_inv = ~coverage;

   always_comb begin
      sum_in = gccb_pkg::SUM_W'(fore_level) * gccb_pkg::SUM_W'(coverage)
             + gccb_pkg::SUM_W'(back_level) * gccb_pkg::SUM_W'(cov_inv);
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      prod     = gccb_pkg::PROD_W'(sum_ff) * gccb_pkg::PROD_W'(gccb_pkg::DIV100_MUL);
      mix      = prod[gccb_pkg::DIV100_SHIFT +: gccb_pkg::CHAN_W];
      pair_sum = {1'b0, dest_chan} + {1'b0, mix};
      chan_out = ctrl.average ? pair_sum[gccb_pkg::CHAN_W:1] : mix;
   end

endmodule

// ----- hw/rtl/glyph_coverage_color_blend_top.sv -----
// ----------------------------------------------------------------------------
// glyph_coverage_color_blend_top
// Blends a glyph coverage sample with the destination pixel using the
// configured foreground and background colors.
//
//   channel   dir   signals
//   req       in    req_valid, req_ready, req_coverage, req_dest_pixel
//   rsp       out   rsp_valid, rsp_ready, rsp_result_pixel, rsp_written
//   csr       in    csr_write_en, csr_index, csr_write_data
//
// Three register stages (input, weighted sum, result): one request per
// cycle unless rsp stalls; rsp_valid rises as the request reaches the
// result stage. The weighted-sum multiply and the divide-by-100
// reciprocal multiply sit in separate stages. Synchronous reset clears
// the stage valids and loads the default colors. A stalled rsp holds the
// pipeline; req_ready drops only when all three stages are full.
// ----------------------------------------------------------------------------
module glyph_coverage_color_blend_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_coverage,
   input  logic [31:0]                   req_dest_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_result_pixel,
   output logic                          rsp_written,
   input  logic                          csr_write_en,
   input  gccb_pkg::csr_index_type       csr_index,
   input  logic [31:0]                   csr_write_data
);

   localparam int CW = gccb_pkg::CHAN_W;
   localparam int LW = gccb_pkg::LEVEL_W;
   localparam int NC = gccb_pkg::NUM_CHAN;

   logic [LW-1:0]                fore_lvl_ff [NC];
   logic [LW-1:0]                back_lvl_ff [NC];
   logic [gccb_pkg::PIXEL_W-1:0] back_color_ff;

   logic                         in_valid_ff;
   logic [CW-1:0]                in_cov_ff;
   logic [gccb_pkg::PIXEL_W-1:0] in_dest_ff;

   logic                         mid_valid_ff;
   logic                         mid_pass_ff;
   logic                         mid_avg_ff;
   logic [gccb_pkg::PIXEL_W-1:0] mid_dest_ff;

   logic                         rsp_valid_ff;
   logic [gccb_pkg::PIXEL_W-1:0] rsp_pixel_ff;
   logic [gccb_pkg::PIXEL_W-1:0] rsp_pixel_in;
   logic                         rsp_written_ff;

   logic                         out_en;
   logic                         mid_en;
   logic                         in_en;
   gccb_pkg::chan_ctrl_type      chan_ctrl;
   logic [CW-1:0]                chan_res [NC];

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign mid_en    = !mid_valid_ff || out_en;
   assign in_en     = !in_valid_ff || mid_en;
   assign req_ready = in_en;

   assign chan_ctrl.sum_en  = mid_en;
   assign chan_ctrl.average = mid_avg_ff;

   // color registers, levels looked up at write time
   always_ff @(posedge clock) begin
      if (reset) begin
         back_color_ff <= '0;
         for (int c = 0; c < NC; c++) begin
            fore_lvl_ff[c] <= gccb_pkg::level_of(gccb_pkg::COVER_FULL);
            back_lvl_ff[c] <= gccb_pkg::level_of(gccb_pkg::COVER_EMPTY);
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            gccb_pkg::CSR_FORE_COLOR: begin
               for (int c = 0; c < NC; c++) begin
                  fore_lvl_ff[c] <= gccb_pkg::level_of(csr_write_data[CW*c +: CW]);
               end
            end
            gccb_pkg::CSR_BACK_COLOR: begin
               back_color_ff <= csr_write_data;
               for (int c = 0; c < NC; c++) begin
                  back_lvl_ff[c] <= gccb_pkg::level_of(csr_write_data[CW*c +: CW]);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_en) begin
            in_valid_ff <= req_valid;
         end
         if (mid_en) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= mid_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_en) begin
         in_cov_ff  <= req_coverage;
         in_dest_ff <= req_dest_pixel;
      end
      if (mid_en) begin
         mid_pass_ff <= (in_cov_ff == gccb_pkg::COVER_EMPTY);
         mid_avg_ff  <= !((in_cov_ff == gccb_pkg::COVER_FULL) ||
                          (in_dest_ff == back_color_ff));
         mid_dest_ff <= in_dest_ff;
      end
      if (out_en) begin
         rsp_pixel_ff   <= rsp_pixel_in;
         rsp_written_ff <= !mid_pass_ff;
      end
   end

   for (genvar c = 0; c < NC; c++) begin : g_chan
      gccb_channel u_chan (
         .clock      (clock),
         .ctrl       (chan_ctrl),
         .fore_level (fore_lvl_ff[c]),
         .back_level (back_lvl_ff[c]),
         .coverage   (in_cov_ff),
         .dest_chan  (mid_dest_ff[CW*c +: CW]),
         .chan_out   (chan_res[c])
      );
   end

   always_comb begin
      if (mid_pass_ff) begin
         rsp_pixel_in = mid_dest_ff;
      end else begin
         rsp_pixel_in = {8'h00, chan_res[2], chan_res[1], chan_res[0]};
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_pixel_ff;
   assign rsp_written      = rsp_written_ff;

   a_written_top_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_written |-> rsp_result_pixel[31:24] == 8'h00)
      else $error("computed pixel has nonzero top byte");

   a_accept_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted request not held in input stage");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && mid_valid_ff && rsp_valid && !rsp_ready)
      else $error("request stalled with room in pipeline");

   a_mid_advances: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && mid_en |=> rsp_valid_ff)
      else $error("sum stage item lost");

endmodule
